>>> hw/rtl/ecps_pkg.sv
// ----------------------------------------------------------------------------
// Encoder position and speed package
// Shared widths, codes, item and configuration types, and the back-end
// state encoding.
// ----------------------------------------------------------------------------
package ecps_pkg;

  // Field and register widths.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CPR_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CPR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  // Configuration reset values.
  localparam logic [CPR_W-1:0]  CPR_RESET     = 8'd64;
  localparam logic              FWD_RESET     = 1'b1;
  localparam logic [DATA_W-1:0] TIMEOUT_RESET = 32'd300000;

  // Pulse kind codes on the input channel.
  localparam logic [1:0] KIND_CW  = 2'd0;
  localparam logic [1:0] KIND_CCW = 2'd1;

  // Microseconds per minute, the RPM scale factor.
  localparam int unsigned       RPM_SCALE_W = 26;
  localparam logic [RPM_SCALE_W-1:0] RPM_SCALE = 26'd60000000;

  // Shared divider: 32 bit magnitude times the scale, over an 8 x 32 product.
  localparam int unsigned DIV_NUM_W = DATA_W + RPM_SCALE_W - 1;
  localparam int unsigned DIV_DEN_W = DATA_W + CPR_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Queue between the front and back ends.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Saturation limits.
  localparam logic [DATA_W-1:0] SPEED_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SPEED_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_PULSE   = 2'd0,
    OP_QUERY   = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  typedef struct packed {
    op_t               op;
    step_t             step;
    logic [DATA_W-1:0] now;
  } item_t;

  typedef struct packed {
    logic [CPR_W-1:0]  cpr;
    logic              fwd;
    logic [DATA_W-1:0] timeout;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_MUL   = 3'd1,
    ST_CDIV  = 3'd2,
    ST_CWAIT = 3'd3,
    ST_PDIV  = 3'd4,
    ST_PWAIT = 3'd5,
    ST_DONE  = 3'd6
  } back_state_t;

endpackage

>>> hw/rtl/encoder_position_and_speed_core.sv
// ----------------------------------------------------------------------------
// Encoder position and speed core
// Pulse, clear and restart items pass the front stage, queue and output
// registers; a new one is taken every cycle while the back end is idle and
// the output is free. A query makes up to two passes through the shared
// bit-serial divider; the input stalls once the front stage and queue fill.
// Synchronous reset clears all state and loads the register reset values.
// ----------------------------------------------------------------------------
module encoder_position_and_speed_core import ecps_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_opcode,
  input  logic [1:0]               in_pulse_kind,
  input  logic [DATA_W-1:0]        in_now_us,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_position_count,
  output logic                     out_last_direction,
  output logic signed [DATA_W-1:0] out_count_speed_rpm,
  output logic signed [DATA_W-1:0] out_period_speed_rpm
);

  cfg_t                 cfg_r, cfg_nxt;
  logic                 push;
  item_t                push_item;
  logic                 q_full;
  logic                 q_valid;
  item_t                q_item;
  logic                 q_pop;
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quot;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CPR:     cfg_nxt.cpr     = cfg_wdata[CPR_W-1:0];
        CFG_FWD:     cfg_nxt.fwd     = cfg_wdata[0];
        CFG_TIMEOUT: cfg_nxt.timeout = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cpr     <= CPR_RESET;
      cfg_r.fwd     <= FWD_RESET;
      cfg_r.timeout <= TIMEOUT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ecps_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_pulse_kind (in_pulse_kind),
    .in_now_us     (in_now_us),
    .push          (push),
    .push_item     (push_item),
    .q_full        (q_full)
  );

  ecps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  ecps_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_start (div_start),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_done  (div_done),
    .div_quot  (div_quot)
  );

  ecps_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_valid              (q_valid),
    .q_item               (q_item),
    .q_pop                (q_pop),
    .div_start            (div_start),
    .div_num              (div_num),
    .div_den              (div_den),
    .div_done             (div_done),
    .div_quot             (div_quot),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_position_count   (out_position_count),
    .out_last_direction   (out_last_direction),
    .out_count_speed_rpm  (out_count_speed_rpm),
    .out_period_speed_rpm (out_period_speed_rpm)
  );

endmodule

>>> hw/rtl/ecps_front.sv
// ----------------------------------------------------------------------------
// Encoder front end
// Accepts input items, decodes opcode and pulse kind into an item record,
// and pushes the record into the work queue.
// ----------------------------------------------------------------------------
module ecps_front import ecps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [1:0]        in_pulse_kind,
  input  logic [DATA_W-1:0] in_now_us,
  output logic              push,
  output item_t             push_item,
  input  logic              q_full
);

  logic  stage_valid_r, stage_valid_nxt;
  item_t stage_item_r, stage_item_nxt;
  step_t step_dec;

  // Decode the pulse kind; both flags and the unused code do not move the count.
  always_comb begin
    case (in_pulse_kind)
      KIND_CW:  step_dec = STEP_DOWN;
      KIND_CCW: step_dec = STEP_UP;
      default:  step_dec = STEP_NONE;
    endcase
  end

  // The stage drains into the queue whenever the queue has room.
  assign push      = stage_valid_r && !q_full;
  assign push_item = stage_item_r;
  assign in_ready  = !stage_valid_r || push;

  always_comb begin
    stage_valid_nxt = stage_valid_r && !push;
    stage_item_nxt  = stage_item_r;
    if (in_valid && in_ready) begin
      stage_valid_nxt     = 1'b1;
      stage_item_nxt.op   = op_t'(in_opcode);
      stage_item_nxt.step = step_dec;
      stage_item_nxt.now  = in_now_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_item_r <= stage_item_nxt;
  end

endmodule

>>> hw/rtl/ecps_queue.sv
// ----------------------------------------------------------------------------
// Encoder work queue
// Short first-in first-out buffer of decoded items between the front and
// back ends.
// ----------------------------------------------------------------------------
module ecps_queue import ecps_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  q_full,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_pop
);

  item_t                  mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> hw/rtl/ecps_div.sv
// ----------------------------------------------------------------------------
// Encoder speed divider
// Restoring unsigned divider, one quotient bit per cycle, shared by both
// speed computations.
// ----------------------------------------------------------------------------
module ecps_div import ecps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 div_start,
  input  logic [DIV_NUM_W-1:0] div_num,
  input  logic [DIV_DEN_W-1:0] div_den,
  output logic                 div_done,
  output logic [DIV_NUM_W-1:0] div_quot
);

  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;

  // One trial subtraction per cycle; quotient bits shift in where the
  // dividend bits shift out. The top bit of the difference is the borrow.
  always_comb begin
    rem_sh   = {rem_r, num_r[DIV_NUM_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (div_start) begin
      num_nxt = div_num;
      den_nxt = div_den;
      rem_nxt = '0;
      cnt_nxt = DIV_CNT_W'(DIV_NUM_W);
    end else if (cnt_r != '0) begin
      if (!rem_sub[DIV_DEN_W]) begin
        rem_nxt = rem_sub[DIV_DEN_W-1:0];
        num_nxt = {num_r[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DIV_DEN_W-1:0];
        num_nxt = {num_r[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign div_done = done_r;
  assign div_quot = num_r;

endmodule

>>> hw/rtl/ecps_back.sv
// ----------------------------------------------------------------------------
// Encoder back end
// Holds the position and rotation state, carries out each queued item and
// sequences the two speed divisions of a query into the output register.
// ----------------------------------------------------------------------------
module ecps_back import ecps_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     q_valid,
  input  item_t                    q_item,
  output logic                     q_pop,
  output logic                     div_start,
  output logic [DIV_NUM_W-1:0]     div_num,
  output logic [DIV_DEN_W-1:0]     div_den,
  input  logic                     div_done,
  input  logic [DIV_NUM_W-1:0]     div_quot,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_position_count,
  output logic                     out_last_direction,
  output logic signed [DATA_W-1:0] out_count_speed_rpm,
  output logic signed [DATA_W-1:0] out_period_speed_rpm
);

  back_state_t state_r, state_nxt;

  // Encoder state.
  logic [DATA_W-1:0] pos_r, pos_nxt;
  logic              dir_r, dir_nxt;
  logic [DATA_W-1:0] start_r, start_nxt;
  logic [DATA_W-1:0] period_r, period_nxt;
  logic [CPR_W-1:0]  pir_r, pir_nxt;
  logic [DATA_W-1:0] caq_r, caq_nxt;
  logic [DATA_W-1:0] taq_r, taq_nxt;

  // Query working registers.
  logic [DATA_W-1:0]    mag_r, mag_nxt;
  logic [DATA_W-1:0]    dt_r, dt_nxt;
  logic                 cs_run_r, cs_run_nxt;
  logic                 cs_neg_r, cs_neg_nxt;
  logic                 ps_run_r, ps_run_nxt;
  logic                 ps_neg_r, ps_neg_nxt;
  logic [DIV_NUM_W-1:0] prod_r, prod_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DATA_W-1:0]    cs_r, cs_nxt;
  logic [DATA_W-1:0]    ps_r, ps_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_pos_r, out_pos_nxt;
  logic              out_dir_r, out_dir_nxt;
  logic [DATA_W-1:0] out_cs_r, out_cs_nxt;
  logic [DATA_W-1:0] out_ps_r, out_ps_nxt;

  logic                 out_free;
  logic                 load_out;
  logic [CPR_W-1:0]     pir_inc;
  logic [DATA_W-1:0]    cnt_diff;
  logic [DATA_W-1:0]    since_start;
  logic [DIV_NUM_W-1:0] mul_full;
  logic [DIV_DEN_W-1:0] den_full;

  // Signed saturation of a quotient magnitude.
  function automatic logic [DATA_W-1:0] sat_speed(input logic [DIV_NUM_W-1:0] q,
                                                  input logic neg);
    logic big;
    big = |q[DIV_NUM_W-1:DATA_W-1];
    if (neg) begin
      sat_speed = big ? SPEED_MIN : (DATA_W'(0) - q[DATA_W-1:0]);
    end else begin
      sat_speed = big ? SPEED_MAX : q[DATA_W-1:0];
    end
  endfunction

  assign out_free    = !out_valid_r || out_ready;
  assign pir_inc     = pir_r + 1'b1;
  assign cnt_diff    = pos_r - caq_r;
  assign since_start = q_item.now - start_r;
  // The magnitude is at most 2^31, so the product fits the dividend width.
  assign mul_full    = DIV_NUM_W'(mag_r) * DIV_NUM_W'(RPM_SCALE);
  assign den_full    = DIV_DEN_W'(cfg.cpr) * DIV_DEN_W'(dt_r);

  // Item execution and query sequencing.
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    dir_nxt       = dir_r;
    start_nxt     = start_r;
    period_nxt    = period_r;
    pir_nxt       = pir_r;
    caq_nxt       = caq_r;
    taq_nxt       = taq_r;
    mag_nxt       = mag_r;
    dt_nxt        = dt_r;
    cs_run_nxt    = cs_run_r;
    cs_neg_nxt    = cs_neg_r;
    ps_run_nxt    = ps_run_r;
    ps_neg_nxt    = ps_neg_r;
    prod_nxt      = prod_r;
    den_nxt       = den_r;
    cs_nxt        = cs_r;
    ps_nxt        = ps_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_pos_nxt   = out_pos_r;
    out_dir_nxt   = out_dir_r;
    out_cs_nxt    = out_cs_r;
    out_ps_nxt    = out_ps_r;
    load_out      = 1'b0;
    q_pop         = 1'b0;
    div_start     = 1'b0;
    div_num       = prod_r;
    div_den       = den_r;

    case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop  = 1'b1;
          cs_nxt = '0;
          ps_nxt = '0;
          case (q_item.op)
            OP_PULSE: begin
              case (q_item.step)
                STEP_UP: begin
                  pos_nxt = pos_r + 1'b1;
                  dir_nxt = 1'b1;
                end
                STEP_DOWN: begin
                  pos_nxt = pos_r - 1'b1;
                  dir_nxt = 1'b0;
                end
                default: ;
              endcase
              // A full rotation latches the period and restarts timing.
              if (pir_inc == cfg.cpr) begin
                period_nxt = q_item.now - start_r;
                start_nxt  = q_item.now;
                pir_nxt    = '0;
              end else begin
                pir_nxt = pir_inc;
              end
              load_out = 1'b1;
            end
            OP_QUERY: begin
              // Count speed operands.
              if (cnt_diff == '0) begin
                taq_nxt    = q_item.now;
                cs_run_nxt = 1'b0;
              end else begin
                caq_nxt    = pos_r;
                dt_nxt     = q_item.now - taq_r;
                taq_nxt    = q_item.now;
                mag_nxt    = cnt_diff[DATA_W-1] ? (DATA_W'(0) - cnt_diff) : cnt_diff;
                cs_neg_nxt = cnt_diff[DATA_W-1] ^ !cfg.fwd;
                cs_run_nxt = 1'b1;
              end
              // Period speed operands, with the timeout restart.
              ps_neg_nxt = (dir_r != cfg.fwd);
              if (period_r == '0) begin
                ps_run_nxt = 1'b0;
              end else if (since_start > cfg.timeout) begin
                start_nxt  = q_item.now;
                period_nxt = '0;
                ps_run_nxt = 1'b0;
              end else begin
                ps_run_nxt = 1'b1;
              end
              state_nxt = ST_MUL;
            end
            OP_CLEAR: begin
              pos_nxt    = '0;
              dir_nxt    = 1'b1;
              start_nxt  = '0;
              period_nxt = '0;
              caq_nxt    = '0;
              taq_nxt    = '0;
              load_out   = 1'b1;
            end
            OP_RESTART: begin
              start_nxt  = q_item.now;
              period_nxt = '0;
              load_out   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        prod_nxt  = mul_full;
        den_nxt   = den_full;
        state_nxt = ST_CDIV;
      end
      ST_CDIV: begin
        if (!cs_run_r) begin
          cs_nxt    = '0;
          state_nxt = ST_PDIV;
        end else if (den_r == '0) begin
          cs_nxt    = cs_neg_r ? SPEED_MIN : SPEED_MAX;
          state_nxt = ST_PDIV;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_CWAIT;
        end
      end
      ST_CWAIT: begin
        if (div_done) begin
          cs_nxt    = sat_speed(div_quot, cs_neg_r);
          state_nxt = ST_PDIV;
        end
      end
      ST_PDIV: begin
        div_num = DIV_NUM_W'(RPM_SCALE);
        div_den = DIV_DEN_W'(period_r);
        if (ps_run_r) begin
          div_start = 1'b1;
          state_nxt = ST_PWAIT;
        end else begin
          ps_nxt    = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_PWAIT: begin
        if (div_done) begin
          ps_nxt    = sat_speed(div_quot, ps_neg_r);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Result transfer into the output register.
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_pos_nxt   = pos_nxt;
      out_dir_nxt   = dir_nxt;
      out_cs_nxt    = cs_nxt;
      out_ps_nxt    = ps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      dir_r       <= 1'b1;
      start_r     <= '0;
      period_r    <= '0;
      pir_r       <= '0;
      caq_r       <= '0;
      taq_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      dir_r       <= dir_nxt;
      start_r     <= start_nxt;
      period_r    <= period_nxt;
      pir_r       <= pir_nxt;
      caq_r       <= caq_nxt;
      taq_r       <= taq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    dt_r      <= dt_nxt;
    cs_run_r  <= cs_run_nxt;
    cs_neg_r  <= cs_neg_nxt;
    ps_run_r  <= ps_run_nxt;
    ps_neg_r  <= ps_neg_nxt;
    prod_r    <= prod_nxt;
    den_r     <= den_nxt;
    cs_r      <= cs_nxt;
    ps_r      <= ps_nxt;
    out_pos_r <= out_pos_nxt;
    out_dir_r <= out_dir_nxt;
    out_cs_r  <= out_cs_nxt;
    out_ps_r  <= out_ps_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_position_count   = $signed(out_pos_r);
  assign out_last_direction   = out_dir_r;
  assign out_count_speed_rpm  = $signed(out_cs_r);
  assign out_period_speed_rpm = $signed(out_ps_r);

endmodule

>>> sim/encoder_position_and_speed_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder position and speed core testbench
// Drives timestamped pulse, query, clear and restart items through the core
// under random flow control on both channels. A behavioral predictor of the
// position count, the rotation period and both speed calculations supplies
// the expected result of every accepted item. A short directed table covers
// the field extremes and corner cases, then random pulse bursts follow under
// several register settings.
// ----------------------------------------------------------------------------
module encoder_position_and_speed_core_tb;
  import ecps_pkg::*;

  // Pulse kinds that leave the count alone, and the register index with no
  // register behind it.
  localparam logic [1:0]           KIND_BOTH  = 2'd2;
  localparam logic [1:0]           KIND_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned HOLD_AFTER  = 45;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef enum logic [1:0] {
    IDLE_RX_HEAVY = 2'd0,
    IDLE_TX_HEAVY = 2'd1,
    IDLE_NONE     = 2'd2
  } idle_mode_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] position;
    logic                     direction;
    logic signed [DATA_W-1:0] count_rpm;
    logic signed [DATA_W-1:0] period_rpm;
  } enc_result_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DATA_W-1:0]    cfg_val;
    op_t                  op;
    logic [1:0]           kind;
    logic [DATA_W-1:0]    now;
    bit                   typed;
    enc_result_t          want;
  } script_row_t;

  typedef struct packed {
    logic [CPR_W-1:0]  cpr;
    logic              fwd;
    logic [DATA_W-1:0] timeout;
    logic [9:0]        items;
    idle_mode_t        mode;
  } rand_phase_t;

  localparam rand_phase_t RAND_PHASES [6] = '{
    '{8'd64,  1'b1, 32'd300000,     10'd30,  IDLE_RX_HEAVY},
    '{8'd1,   1'b0, 32'hFFFF_FFFF,  10'd40,  IDLE_RX_HEAVY},
    '{8'd255, 1'b1, 32'd1,          10'd30,  IDLE_TX_HEAVY},
    '{8'd0,   1'b0, 32'd0,          10'd260, IDLE_TX_HEAVY},
    '{8'd3,   1'b1, 32'd2000,       10'd30,  IDLE_NONE},
    '{8'd7,   1'b0, 32'd300000,     10'd30,  IDLE_NONE}
  };

  // DUT connections, with every input driven to a known value from time zero.
  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_opcode = '0;
  logic [1:0]               in_pulse_kind = '0;
  logic [DATA_W-1:0]        in_now_us = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_position_count;
  logic                     out_last_direction;
  logic signed [DATA_W-1:0] out_count_speed_rpm;
  logic signed [DATA_W-1:0] out_period_speed_rpm;

  // Predictor registers and state, at their reset values.
  logic [CPR_W-1:0]  cfg_cpr = CPR_RESET;
  logic              cfg_fwd = FWD_RESET;
  logic [DATA_W-1:0] cfg_timeout = TIMEOUT_RESET;
  logic [DATA_W-1:0] pos_count = '0;
  logic              dir_ccw = 1'b1;
  logic [DATA_W-1:0] rot_start_us = '0;
  logic [DATA_W-1:0] rot_period_us = '0;
  logic [CPR_W-1:0]  rot_pulses = '0;
  logic [DATA_W-1:0] query_count_ref = '0;
  logic [DATA_W-1:0] query_time_ref = '0;

  enc_result_t       expected_results[$];
  enc_result_t       head_result;
  script_row_t       script[$];
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       err_count = 0;
  int unsigned       results_seen = 0;
  int unsigned       hold_left = 0;
  bit                hold_done = 1'b0;
  int unsigned       cycle_count = 0;

  encoder_position_and_speed_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opcode            (in_opcode),
    .in_pulse_kind        (in_pulse_kind),
    .in_now_us            (in_now_us),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_position_count   (out_position_count),
    .out_last_direction   (out_last_direction),
    .out_count_speed_rpm  (out_count_speed_rpm),
    .out_period_speed_rpm (out_period_speed_rpm)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp a speed magnitude with its sign into the signed 32 bit range.
  function automatic logic [DATA_W-1:0] saturate_rpm(logic [63:0] mag, bit neg);
    logic [DATA_W-1:0] low;
    low = mag[DATA_W-1:0];
    if (neg) begin
      return (mag >= 64'h8000_0000) ? SPEED_MIN : (~low + 32'd1);
    end
    return (mag > 64'h7fff_ffff) ? SPEED_MAX : low;
  endfunction

  // Speed from the count change since the previous query.
  function automatic logic [DATA_W-1:0] count_rpm_of(logic [DATA_W-1:0] now);
    logic [DATA_W-1:0] diff;
    logic [DATA_W-1:0] dt;
    logic [63:0]       mag;
    logic [63:0]       den;
    bit                neg;
    if (pos_count == query_count_ref) begin
      query_time_ref = now;
      return '0;
    end
    diff = pos_count - query_count_ref;
    query_count_ref = pos_count;
    dt = now - query_time_ref;
    query_time_ref = now;
    neg = diff[DATA_W-1];
    mag = neg ? {32'd0, ~diff + 32'd1} : {32'd0, diff};
    if (!cfg_fwd) neg = !neg;
    den = {56'd0, cfg_cpr} * {32'd0, dt};
    if (den == 64'd0) return saturate_rpm(64'h8000_0000, neg);
    return saturate_rpm((mag * 64'(RPM_SCALE)) / den, neg);
  endfunction

  // Speed from the latched rotation period; a stale period restarts timing.
  function automatic logic [DATA_W-1:0] period_rpm_of(logic [DATA_W-1:0] now);
    logic [DATA_W-1:0] since;
    if (rot_period_us == '0) return '0;
    since = now - rot_start_us;
    if (since > cfg_timeout) begin
      rot_start_us = now;
      rot_period_us = '0;
      return '0;
    end
    return saturate_rpm(64'(RPM_SCALE) / {32'd0, rot_period_us}, dir_ccw != cfg_fwd);
  endfunction

  // Advance the predicted state by one item and return its result.
  function automatic enc_result_t apply_item(op_t op, logic [1:0] kind,
                                             logic [DATA_W-1:0] now);
    enc_result_t res;
    res.count_rpm = '0;
    res.period_rpm = '0;
    case (op)
      OP_PULSE: begin
        if (kind == KIND_CW) begin
          pos_count = pos_count - 32'd1;
          dir_ccw = 1'b0;
        end else if (kind == KIND_CCW) begin
          pos_count = pos_count + 32'd1;
          dir_ccw = 1'b1;
        end
        rot_pulses = rot_pulses + 8'd1;
        if (rot_pulses == cfg_cpr) begin
          rot_period_us = now - rot_start_us;
          rot_start_us = now;
          rot_pulses = '0;
        end
      end
      OP_QUERY: begin
        res.count_rpm = count_rpm_of(now);
        res.period_rpm = period_rpm_of(now);
      end
      OP_CLEAR: begin
        pos_count = '0;
        dir_ccw = 1'b1;
        rot_start_us = '0;
        rot_period_us = '0;
        query_count_ref = '0;
        query_time_ref = '0;
      end
      default: begin
        rot_start_us = now;
        rot_period_us = '0;
      end
    endcase
    res.position = pos_count;
    res.direction = dir_ccw;
    return res;
  endfunction

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_RX_HEAVY: begin
        send_idle_pct = 27;
        recv_idle_pct = 61;
      end
      IDLE_TX_HEAVY: begin
        send_idle_pct = 61;
        recv_idle_pct = 27;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Offer one item, hold it until the transfer, then record its expectation.
  task automatic send_item(input op_t op, input logic [1:0] kind,
                           input logic [DATA_W-1:0] now, input bit typed,
                           input enc_result_t typed_res);
    enc_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_pulse_kind <= kind;
    in_now_us     <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_item(op, kind, now);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  // Stop offering and wait until every expected result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CPR:     cfg_cpr = val[CPR_W-1:0];
      CFG_FWD:     cfg_fwd = val[0];
      CFG_TIMEOUT: cfg_timeout = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    script_row_t row;
    row = '{op: OP_PULSE, default: '0};
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    script.push_back(row);
  endfunction

  function automatic void add_step(op_t op, logic [1:0] kind, logic [DATA_W-1:0] now,
                                   bit typed, logic signed [DATA_W-1:0] pos,
                                   logic dir, logic signed [DATA_W-1:0] cs,
                                   logic signed [DATA_W-1:0] ps);
    script_row_t row;
    row = '{op: OP_PULSE, default: '0};
    row.op = op;
    row.kind = kind;
    row.now = now;
    row.typed = typed;
    row.want = {pos, dir, cs, ps};
    script.push_back(row);
  endfunction

  // Result side: random or long stalls, and a check of every transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no expectation pending");
          err_count++;
        end else begin
          head_result = expected_results.pop_front();
          if (out_position_count !== head_result.position) begin
            $error("position_count: expected %0d, got %0d",
                   head_result.position, out_position_count);
            err_count++;
          end
          if (out_last_direction !== head_result.direction) begin
            $error("last_direction: expected %0d, got %0d",
                   head_result.direction, out_last_direction);
            err_count++;
          end
          if (out_count_speed_rpm !== head_result.count_rpm) begin
            $error("count_speed_rpm: expected %0d, got %0d",
                   head_result.count_rpm, out_count_speed_rpm);
            err_count++;
          end
          if (out_period_speed_rpm !== head_result.period_rpm) begin
            $error("period_speed_rpm: expected %0d, got %0d",
                   head_result.period_rpm, out_period_speed_rpm);
            err_count++;
          end
        end
      end
      if (!hold_done && results_seen == HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus: directed table, then random phases.
  initial begin
    logic [DATA_W-1:0] clock_us;
    int unsigned       sent;
    int unsigned       sel;
    int unsigned       burst;
    bit                fast;
    logic [1:0]        kind_main;
    logic [1:0]        kind;

    // Reset config; five pulses leave the rotation counter at five.
    add_step(OP_PULSE,   KIND_CCW,   32'd0,         1, 1,  1'b1, 0, 0);
    add_step(OP_QUERY,   KIND_CW,    32'd0,         1, 1,  1'b1, SPEED_MAX, 0);
    add_step(OP_PULSE,   KIND_CW,    32'd5,         1, 0,  1'b0, 0, 0);
    add_step(OP_PULSE,   KIND_CW,    32'd6,         1, -1, 1'b0, 0, 0);
    add_step(OP_PULSE,   KIND_BOTH,  32'd7,         1, -1, 1'b0, 0, 0);
    add_step(OP_PULSE,   KIND_SPARE, 32'd8,         1, -1, 1'b0, 0, 0);
    add_step(OP_QUERY,   KIND_SPARE, 32'hFFFF_FFFF, 1, -1, 1'b0, 0, 0);
    add_step(OP_CLEAR,   KIND_SPARE, 32'hFFFF_FFFF, 1, 0,  1'b1, 0, 0);
    add_step(OP_RESTART, KIND_BOTH,  32'd123,       1, 0,  1'b1, 0, 0);
    // Six pulses per rotation: the next pulse latches a period.
    add_cfg(CFG_CPR, 32'hFFFF_FF06);
    add_cfg(CFG_TIMEOUT, 32'd1000);
    add_cfg(CFG_UNUSED, 32'hFFFF_FFFF);
    add_step(OP_PULSE,   KIND_CCW,   32'd200,       0, 0, 1'b0, 0, 0);
    add_step(OP_QUERY,   KIND_CW,    32'd300,       0, 0, 1'b0, 0, 0);
    // Reverse sense, one pulse per rotation, then a period timeout.
    add_cfg(CFG_FWD, 32'd0);
    add_cfg(CFG_CPR, 32'd1);
    add_step(OP_PULSE,   KIND_CW,    32'd400,       0, 0, 1'b0, 0, 0);
    add_step(OP_PULSE,   KIND_CW,    32'd401,       0, 0, 1'b0, 0, 0);
    add_step(OP_QUERY,   KIND_CW,    32'd401,       0, 0, 1'b0, 0, 0);
    add_step(OP_QUERY,   KIND_CW,    32'd5000,      0, 0, 1'b0, 0, 0);
    add_step(OP_QUERY,   KIND_CW,    32'd5001,      0, 0, 1'b0, 0, 0);
    // Zero pulses per rotation saturates the count speed, negated here.
    add_cfg(CFG_CPR, 32'd0);
    add_step(OP_PULSE,   KIND_CCW,   32'd6000,      0, 0, 1'b0, 0, 0);
    add_step(OP_QUERY,   KIND_CW,    32'd6001,      1, 0, 1'b1, SPEED_MIN, 0);
    // Widest registers and a timestamp wrap between pulse and query.
    add_cfg(CFG_CPR, 32'd255);
    add_cfg(CFG_FWD, 32'd1);
    add_cfg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    add_step(OP_PULSE,   KIND_CCW,   32'hFFFF_FFF0, 0, 0, 1'b0, 0, 0);
    add_step(OP_QUERY,   KIND_CCW,   32'h0000_0010, 0, 0, 1'b0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(IDLE_RX_HEAVY);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        write_cfg(script[i].cfg_idx, script[i].cfg_val);
      end else begin
        send_item(script[i].op, script[i].kind, script[i].now, script[i].typed,
                  script[i].want);
      end
    end

    // Random phases: mostly pulse bursts closed by a query, with clears,
    // restarts, long time jumps and raw noise mixed in.
    clock_us = $urandom;
    foreach (RAND_PHASES[p]) begin
      write_cfg(CFG_CPR, {24'd0, RAND_PHASES[p].cpr});
      write_cfg(CFG_FWD, {31'd0, RAND_PHASES[p].fwd});
      write_cfg(CFG_TIMEOUT, RAND_PHASES[p].timeout);
      set_idle(RAND_PHASES[p].mode);
      sent = 0;
      while (sent < RAND_PHASES[p].items) begin
        sel = $urandom_range(99);
        if (sel < 70) begin
          // Fast bursts keep time still so the query sees a tiny interval.
          burst = $urandom_range(60, 1);
          fast = ($urandom_range(3) == 0);
          kind_main = $urandom_range(1) ? KIND_CCW : KIND_CW;
          repeat (burst) begin
            kind = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : kind_main;
            if (!fast) clock_us = clock_us + $urandom_range(200);
            send_item(OP_PULSE, kind, clock_us, 0, '0);
          end
          clock_us = clock_us + (fast ? $urandom_range(2) : $urandom_range(5000));
          send_item(OP_QUERY, 2'($urandom_range(3)), clock_us, 0, '0);
          sent += burst + 1;
        end else if (sel < 80) begin
          clock_us = clock_us + $urandom;
          send_item(OP_QUERY, 2'($urandom_range(3)), clock_us, 0, '0);
          sent++;
        end else if (sel < 87) begin
          send_item(OP_CLEAR, 2'($urandom_range(3)), clock_us, 0, '0);
          sent++;
        end else if (sel < 94) begin
          send_item(OP_RESTART, 2'($urandom_range(3)), clock_us, 0, '0);
          sent++;
        end else begin
          send_item(op_t'($urandom_range(3)), 2'($urandom_range(3)), $urandom, 0, '0);
          sent++;
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
